// File: src/glos_pkg.sv
// Shared constants and types for the grid line-of-sight block.
// No dependencies; used by glos_sqr and grid_line_of_sight_top.
package glos_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int DIM_W     = 9;                    // grid_rows / grid_cols register width
    localparam int ROW_AW    = $clog2(MAX_ROWS);     // occupancy row address
    localparam int COL_AW    = $clog2(MAX_COLS);     // bit select in a row
    localparam int CRD_W     = 8;                    // coordinate field width
    localparam int AR_W      = 12;                   // signed walk arithmetic
    localparam int SQ_W      = 22;                   // square of an AR_W operand
    localparam int LEN_W     = 18;                   // di^2 + dj^2
    localparam int IN_W      = 40;                   // s_tdata width
    localparam int OUT_W     = 8;                    // m_tdata width
    localparam int CFG_AW    = 2;

    localparam logic [CFG_AW-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GRID_COLS = 2'd1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_RECT  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // which cell of a walk step is probed
    typedef enum logic [2:0] {
        PH_CUR  = 3'd0,   // current cell
        PH_SIDE = 3'd1,   // side cell, one minor step
        PH_AHD  = 3'd2,   // one major step ahead
        PH_SIDE2= 3'd3,   // two minor steps
        PH_END  = 3'd4    // final cell of a diagonal walk
    } phase_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] x;
        x = v;
        if (x == '0) x = DIM_W'(1);
        if (x > mx) x = mx;
        return x;
    endfunction

endpackage

// File: src/glos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/glos_sqr.sv
// Shared squaring unit: registered square of a signed operand.
// Depends on glos_pkg.
module glos_sqr (
    input  logic                              aclk,
    input  logic signed [glos_pkg::AR_W-1:0]  op,
    output logic        [glos_pkg::SQ_W-1:0]  sq
);
    logic signed [glos_pkg::SQ_W-1:0] op_ext;
    logic signed [glos_pkg::SQ_W-1:0] prod;

    assign op_ext = glos_pkg::SQ_W'(op);
    assign prod   = op_ext * op_ext;

    always_ff @(posedge aclk) begin
        sq <= prod;
    end
endmodule

// File: src/grid_line_of_sight_top.sv
// Grid line-of-sight block: top level with sequencer, row valid bits and config.
// Depends on glos_pkg, glos_ram, glos_sqr.
//
// Keeps a 256 x 256 one-bit occupancy grid as 256 row words in a RAM, each with a
// valid bit (a row that is not valid reads as free), so reset and the clear command
// take effect at once. One input beat is one command and gives one result beat.
// Clear goes straight to the result. Marking a rectangle does a read-modify-write of
// the row word for each row walked. A query walks the major axis; every probe of a
// cell passes through RAM read, bit check and advance, probes off the grid skip the
// bit check, and a minor-axis step adds two passes through the shared squarer.
// The input side is not ready while a command is at work or while its result waits;
// the result is held on m_tdata until taken.
// Config writes (cfg_addr 0 grid_rows, 1 grid_cols) are always accepted and are
// saturated into 1..256; other addresses are dropped.
module grid_line_of_sight_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], row_a[9:2], col_a[17:10], row_b[25:18], col_b[33:26], zero pad
    input  logic [glos_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // visible[0], bad_coords[1], zero pad
    output logic [glos_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [glos_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [glos_pkg::DIM_W-1:0]    cfg_data
);
    localparam int AW = glos_pkg::AR_W;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_RECT_RD = 15'b000000000000010,
        ST_RECT_WR = 15'b000000000000100,
        ST_LEN0    = 15'b000000000001000,
        ST_LEN1    = 15'b000000000010000,
        ST_LEN2    = 15'b000000000100000,
        ST_STEP    = 15'b000000001000000,
        ST_PROBE   = 15'b000000010000000,
        ST_CHK     = 15'b000000100000000,
        ST_NEXT    = 15'b000001000000000,
        ST_SQ1     = 15'b000010000000000,
        ST_SQ1W    = 15'b000100000000000,
        ST_SQ2     = 15'b001000000000000,
        ST_SQ2W    = 15'b010000000000000,
        ST_DONE    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [glos_pkg::DIM_W-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [glos_pkg::MAX_ROWS-1:0] rvalid_reg, rvalid_next;

    logic [glos_pkg::CRD_W-1:0] rb_reg, rb_next, ca_reg, ca_next, cb_reg, cb_next;
    logic [glos_pkg::DIM_W-1:0] r_reg, r_next;

    logic signed [AW-1:0] maj_reg, maj_next, min_reg, min_next, end_reg, end_next;
    logic signed [AW-1:0] smaj_reg, smaj_next, smin_reg, smin_next;
    logic signed [AW-1:0] dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic signed [AW-1:0] err_reg, err_next;
    logic [glos_pkg::LEN_W-1:0] len2_reg, len2_next;
    logic sw_reg, sw_next, straight_reg, straight_next;
    glos_pkg::phase_t phase_reg, phase_next;
    logic [glos_pkg::ROW_AW-1:0] prow_reg, prow_next;
    logic [glos_pkg::COL_AW-1:0] pcol_reg, pcol_next;
    logic vis_reg, vis_next, bad_reg, bad_next;

    // input fields
    glos_pkg::cmd_t             in_cmd;
    logic [glos_pkg::CRD_W-1:0] in_ra, in_ca, in_rb, in_cb;
    assign in_cmd = glos_pkg::cmd_t'(s_tdata[1:0]);
    assign in_ra  = s_tdata[9:2];
    assign in_ca  = s_tdata[17:10];
    assign in_rb  = s_tdata[25:18];
    assign in_cb  = s_tdata[33:26];

    // occupancy RAM and squarer
    logic                               ram_we;
    logic [glos_pkg::ROW_AW-1:0]        ram_waddr, ram_raddr;
    logic [glos_pkg::MAX_COLS-1:0]      ram_wdata, ram_rdata, rect_mask;
    logic signed [AW-1:0]               sq_op;
    logic [glos_pkg::SQ_W-1:0]          sq_out;

    glos_ram #(.WIDTH(glos_pkg::MAX_COLS), .DEPTH(glos_pkg::MAX_ROWS)) u_occ (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    glos_sqr u_sqr (
        .aclk (aclk),
        .op   (sq_op),
        .sq   (sq_out)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_DONE);
    assign m_tdata   = {{(glos_pkg::OUT_W-2){1'b0}}, bad_reg, vis_reg};
    assign cfg_ready = 1'b1;

    // query setup from the input beat
    logic [glos_pkg::CRD_W-1:0] q_di, q_dj;
    logic signed [AW-1:0]       q_si, q_sj;
    logic                       q_sw, q_bad;
    always_comb begin
        q_di  = (in_ra > in_rb) ? in_ra - in_rb : in_rb - in_ra;
        q_dj  = (in_ca > in_cb) ? in_ca - in_cb : in_cb - in_ca;
        q_si  = (in_ra < in_rb) ? AW'(1) : -AW'(1);
        q_sj  = (in_ca < in_cb) ? AW'(1) : -AW'(1);
        q_sw  = q_di > q_dj;
        q_bad = ({1'b0, in_ra} >= rows_reg) || ({1'b0, in_rb} >= rows_reg) ||
                ({1'b0, in_ca} >= cols_reg) || ({1'b0, in_cb} >= cols_reg);
    end

    // rectangle column mask for the row being marked
    always_comb begin
        for (int k = 0; k < glos_pkg::MAX_COLS; k++) begin
            rect_mask[k] = (glos_pkg::DIM_W'(k) >= {1'b0, ca_reg}) &&
                           (glos_pkg::DIM_W'(k) <= {1'b0, cb_reg}) &&
                           (glos_pkg::DIM_W'(k) < cols_reg);
        end
    end

    // probe cell for the current phase
    logic signed [AW-1:0] p_maj, p_min, p_r, p_c;
    logic                 p_off;
    always_comb begin
        p_maj = maj_reg;
        p_min = min_reg;
        case (phase_reg)
            glos_pkg::PH_SIDE:  p_min = min_reg + smin_reg;
            glos_pkg::PH_AHD:   p_maj = maj_reg + smaj_reg;
            glos_pkg::PH_SIDE2: p_min = min_reg + (smin_reg <<< 1);
            default:            p_min = min_reg;
        endcase
        p_r   = sw_reg ? p_maj : p_min;
        p_c   = sw_reg ? p_min : p_maj;
        p_off = (p_r < 0) || (p_c < 0) ||
                (p_r >= $signed(AW'(rows_reg))) || (p_c >= $signed(AW'(cols_reg)));
    end

    // extra-probe distances
    logic signed [AW-1:0] v1, v2;
    logic                 sq_below;
    assign v1       = (err_reg <<< 1) - dmaj_reg - dmin_reg;
    assign v2       = (dmaj_reg <<< 1) + dmaj_reg - (err_reg <<< 1) + dmin_reg;
    assign sq_below = sq_out < glos_pkg::SQ_W'(len2_reg);

    always_comb begin
        unique case (state_reg)
            ST_LEN0: sq_op = dmaj_reg;
            ST_LEN1: sq_op = dmin_reg;
            ST_SQ1:  sq_op = v1;
            ST_SQ2:  sq_op = v2;
            default: sq_op = v1;
        endcase
    end

    logic signed [AW-1:0] err_add;
    assign err_add = err_reg + dmin_reg;

    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        rvalid_next   = rvalid_reg;
        rb_next       = rb_reg;
        ca_next       = ca_reg;
        cb_next       = cb_reg;
        r_next        = r_reg;
        maj_next      = maj_reg;
        min_next      = min_reg;
        end_next      = end_reg;
        smaj_next     = smaj_reg;
        smin_next     = smin_reg;
        dmaj_next     = dmaj_reg;
        dmin_next     = dmin_reg;
        err_next      = err_reg;
        len2_next     = len2_reg;
        sw_next       = sw_reg;
        straight_next = straight_reg;
        phase_next    = phase_reg;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        vis_next      = vis_reg;
        bad_next      = bad_reg;
        ram_we        = 1'b0;
        ram_waddr     = r_reg[glos_pkg::ROW_AW-1:0];
        ram_wdata     = (rvalid_reg[r_reg[glos_pkg::ROW_AW-1:0]] ? ram_rdata : '0) | rect_mask;
        ram_raddr     = (state_reg == ST_RECT_RD) ? r_reg[glos_pkg::ROW_AW-1:0]
                                                  : p_r[glos_pkg::ROW_AW-1:0];

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                glos_pkg::REG_GRID_ROWS:
                    rows_next = glos_pkg::clamp_dim(cfg_data, glos_pkg::DIM_W'(glos_pkg::MAX_ROWS));
                glos_pkg::REG_GRID_COLS:
                    cols_next = glos_pkg::clamp_dim(cfg_data, glos_pkg::DIM_W'(glos_pkg::MAX_COLS));
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    vis_next = 1'b0;
                    bad_next = 1'b0;
                    rb_next  = in_rb;
                    ca_next  = in_ca;
                    cb_next  = in_cb;
                    r_next   = {1'b0, in_ra};
                    err_next = '0;
                    sw_next  = q_sw;
                    if (q_sw) begin
                        maj_next = AW'(in_ra); min_next = AW'(in_ca); end_next = AW'(in_rb);
                        dmaj_next = AW'(q_di); dmin_next = AW'(q_dj);
                        smaj_next = q_si; smin_next = q_sj;
                    end else begin
                        maj_next = AW'(in_ca); min_next = AW'(in_ra); end_next = AW'(in_cb);
                        dmaj_next = AW'(q_dj); dmin_next = AW'(q_di);
                        smaj_next = q_sj; smin_next = q_si;
                    end
                    straight_next = q_sw ? (q_dj == '0) : (q_di == '0);
                    unique case (in_cmd)
                        glos_pkg::CMD_CLEAR: begin
                            rvalid_next = '0;
                            state_next  = ST_DONE;
                        end
                        glos_pkg::CMD_RECT:  state_next = ST_RECT_RD;
                        glos_pkg::CMD_QUERY: begin
                            if (q_bad) begin
                                bad_next   = 1'b1;
                                state_next = ST_DONE;
                            end else if (q_sw ? (q_dj == '0) : (q_di == '0)) begin
                                state_next = ST_STEP;
                            end else begin
                                state_next = ST_LEN0;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RECT_RD: begin
                if (r_reg <= {1'b0, rb_reg} && r_reg < rows_reg) begin
                    state_next = ST_RECT_WR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RECT_WR: begin
                ram_we = 1'b1;
                rvalid_next[r_reg[glos_pkg::ROW_AW-1:0]] = 1'b1;
                r_next     = r_reg + 1'b1;
                state_next = ST_RECT_RD;
            end
            ST_LEN0: state_next = ST_LEN1;
            ST_LEN1: begin
                len2_next  = sq_out[glos_pkg::LEN_W-1:0];
                state_next = ST_LEN2;
            end
            ST_LEN2: begin
                len2_next  = len2_reg + sq_out[glos_pkg::LEN_W-1:0];
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (maj_reg == end_reg) begin
                    if (straight_reg) begin
                        vis_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        phase_next = glos_pkg::PH_END;
                        state_next = ST_PROBE;
                    end
                end else begin
                    phase_next = glos_pkg::PH_CUR;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                prow_next  = p_r[glos_pkg::ROW_AW-1:0];
                pcol_next  = p_c[glos_pkg::COL_AW-1:0];
                // off-grid cells are free: skip the bit check
                state_next = p_off ? ST_NEXT : ST_CHK;
            end
            ST_CHK: begin
                if (rvalid_reg[prow_reg] && ram_rdata[pcol_reg]) begin
                    vis_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                case (phase_reg)
                    glos_pkg::PH_END: begin
                        vis_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    glos_pkg::PH_CUR: begin
                        if (straight_reg) begin
                            maj_next   = maj_reg + smaj_reg;
                            state_next = ST_STEP;
                        end else begin
                            phase_next = glos_pkg::PH_SIDE;
                            state_next = ST_PROBE;
                        end
                    end
                    glos_pkg::PH_SIDE: begin
                        err_next = err_add;
                        if (err_add >= dmaj_reg) begin
                            state_next = ST_SQ1;
                        end else begin
                            maj_next   = maj_reg + smaj_reg;
                            state_next = ST_STEP;
                        end
                    end
                    glos_pkg::PH_AHD: state_next = ST_SQ2;
                    default: begin
                        // minor-axis step done
                        min_next   = min_reg + smin_reg;
                        err_next   = err_reg - dmaj_reg;
                        maj_next   = maj_reg + smaj_reg;
                        state_next = ST_STEP;
                    end
                endcase
            end
            ST_SQ1: state_next = ST_SQ1W;
            ST_SQ1W: begin
                if (sq_below) begin
                    phase_next = glos_pkg::PH_AHD;
                    state_next = ST_PROBE;
                end else begin
                    state_next = ST_SQ2;
                end
            end
            ST_SQ2: state_next = ST_SQ2W;
            ST_SQ2W: begin
                if (sq_below) begin
                    phase_next = glos_pkg::PH_SIDE2;
                    state_next = ST_PROBE;
                end else begin
                    min_next   = min_reg + smin_reg;
                    err_next   = err_reg - dmaj_reg;
                    maj_next   = maj_reg + smaj_reg;
                    state_next = ST_STEP;
                end
            end
            ST_DONE: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rows_reg   <= glos_pkg::DIM_W'(glos_pkg::MAX_ROWS);
            cols_reg   <= glos_pkg::DIM_W'(glos_pkg::MAX_COLS);
            rvalid_reg <= '0;
        end else begin
            state_reg  <= state_next;
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rb_reg       <= rb_next;
        ca_reg       <= ca_next;
        cb_reg       <= cb_next;
        r_reg        <= r_next;
        maj_reg      <= maj_next;
        min_reg      <= min_next;
        end_reg      <= end_next;
        smaj_reg     <= smaj_next;
        smin_reg     <= smin_next;
        dmaj_reg     <= dmaj_next;
        dmin_reg     <= dmin_next;
        err_reg      <= err_next;
        len2_reg     <= len2_next;
        sw_reg       <= sw_next;
        straight_reg <= straight_next;
        phase_reg    <= phase_next;
        prow_reg     <= prow_next;
        pcol_reg     <= pcol_next;
        vis_reg      <= vis_next;
        bad_reg      <= bad_next;
    end

    // never ready for a new beat while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // a flagged endpoint never reports a clear line
    a_bad_not_vis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("bad_coords with visible set");

    // an accepted beat always starts work
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("still ready after accept");

    // an accepted clear command leaves every row word invalid
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[1:0] == glos_pkg::CMD_CLEAR) |=> (rvalid_reg == '0))
        else $error("clear left valid rows");
endmodule

// File: tb/sv/tb_grid_line_of_sight_top.sv
// Self-checking testbench for grid_line_of_sight_top: directed table, small-grid checks, then random commands.
// Depends on glos_pkg and the grid_line_of_sight_top RTL.
module tb_grid_line_of_sight_top;

    typedef struct packed {
        glos_pkg::cmd_t cmd;
        logic [7:0]     ra, ca, rb, cb;
    } los_cmd_t;

    typedef struct packed {
        logic       vis;
        logic       bad;
    } los_res_t;

    // directed row: command, optional typed-in expectation
    typedef struct {
        los_cmd_t   c;
        logic       has_exp;
        los_res_t   e;
    } dir_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [glos_pkg::IN_W-1:0]        s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [glos_pkg::OUT_W-1:0]       m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [glos_pkg::CFG_AW-1:0]      cfg_addr = '0;
    logic [glos_pkg::DIM_W-1:0]       cfg_data = '0;

    grid_line_of_sight_top dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow grid and dimensions
    bit       occ [256][256];
    int       rows_used, cols_used;
    los_res_t exp_q[$];
    int       n_fail;
    bit       hold_rx;       // long receiver hold-off request

    function automatic int sat_dim(logic [glos_pkg::DIM_W-1:0] v);
        int x;
        x = int'(v);
        if (x == 0) x = 1;
        if (x > 256) x = 256;
        return x;
    endfunction

    function automatic bit is_blk(int r, int c);
        if (r < 0 || c < 0 || r >= rows_used || c >= cols_used) return 0;
        return occ[r][c];
    endfunction

    function automatic bit sight_clear(int i1, int j1, int i2, int j2);
        int di, dj, si, sj, i, j, err, len2, t;
        di = i1 > i2 ? i1 - i2 : i2 - i1;
        dj = j1 > j2 ? j1 - j2 : j2 - j1;
        si = i1 < i2 ? 1 : -1;
        sj = j1 < j2 ? 1 : -1;
        i = i1; j = j1; err = 0;
        if (di == 0) begin
            for (; j != j2; j += sj) if (is_blk(i, j)) return 0;
            return 1;
        end
        if (dj == 0) begin
            for (; i != i2; i += si) if (is_blk(i, j)) return 0;
            return 1;
        end
        len2 = di*di + dj*dj;
        if (di > dj) begin
            for (; i != i2; i += si) begin
                if (is_blk(i, j) || is_blk(i, j + sj)) return 0;
                err += dj;
                if (err >= di) begin
                    t = 2*err - di - dj;
                    if (t*t < len2 && is_blk(i + si, j)) return 0;
                    t = 3*di - (2*err - dj);
                    if (t*t < len2 && is_blk(i, j + 2*sj)) return 0;
                    j += sj; err -= di;
                end
            end
        end else begin
            for (; j != j2; j += sj) begin
                if (is_blk(i, j) || is_blk(i + si, j)) return 0;
                err += di;
                if (err >= dj) begin
                    t = 2*err - di - dj;
                    if (t*t < len2 && is_blk(i, j + sj)) return 0;
                    t = 3*dj - (2*err - di);
                    if (t*t < len2 && is_blk(i + 2*si, j)) return 0;
                    i += si; err -= dj;
                end
            end
        end
        return !is_blk(i, j);
    endfunction

    // apply one command to the shadow state, return expected result
    function automatic los_res_t apply_cmd(los_cmd_t c);
        los_res_t res;
        res = '0;
        case (c.cmd)
            glos_pkg::CMD_CLEAR: begin
                foreach (occ[r, k]) occ[r][k] = 0;
            end
            glos_pkg::CMD_RECT: begin
                for (int r = int'(c.ra); r <= int'(c.rb) && r < rows_used; r++)
                    for (int k = int'(c.ca); k <= int'(c.cb) && k < cols_used; k++)
                        occ[r][k] = 1;
            end
            glos_pkg::CMD_QUERY: begin
                if (int'(c.ra) >= rows_used || int'(c.rb) >= rows_used ||
                    int'(c.ca) >= cols_used || int'(c.cb) >= cols_used)
                    res.bad = 1'b1;
                else
                    res.vis = sight_clear(int'(c.ra), int'(c.ca), int'(c.rb), int'(c.cb));
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic tick(int n);
        repeat (n) @(posedge aclk);
    endtask

    // mostly short gaps, a few long
    function automatic int gap_len();
        int p;
        p = int'($urandom_range(99));
        if (p < 55) return 0;
        if (p < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // tvalid stays up across back-to-back beats; it drops only for a gap or in drain
    task automatic send_cmd(los_cmd_t c, bit has_exp, los_res_t e);
        los_res_t pr;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            tick(g);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= glos_pkg::IN_W'({c.cb, c.rb, c.ca, c.ra, c.cmd});
        do @(posedge aclk); while (!s_tready);
        pr = apply_cmd(c);
        if (has_exp && pr !== e) begin
            $error("directed row disagrees with predictor: typed %b predicted %b", e, pr);
            n_fail++;
        end
        exp_q.insert(exp_q.size(), has_exp ? e : pr);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        tick(40);   // no command is still at work once its result arrived
    endtask

    task automatic write_reg(logic [glos_pkg::CFG_AW-1:0] a, logic [glos_pkg::DIM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (a == glos_pkg::REG_GRID_ROWS) rows_used = sat_dim(v);
        else cols_used = sat_dim(v);
        @(posedge aclk);
    endtask

    function automatic los_cmd_t mk(glos_pkg::cmd_t op, int ra, int ca, int rb, int cb);
        los_cmd_t c;
        c.cmd = op; c.ra = 8'(ra); c.ca = 8'(ca); c.rb = 8'(rb); c.cb = 8'(cb);
        return c;
    endfunction

    // random coordinate biased toward the grid in use and its edges
    function automatic logic [7:0] rnd_crd(int lim);
        int p;
        p = int'($urandom_range(99));
        if (p < 80) return 8'($urandom_range(lim - 1 > 255 ? 255 : lim - 1));
        if (p < 90) return 8'(lim > 255 ? 255 : lim);
        return 8'($urandom_range(255));
    endfunction

    function automatic los_cmd_t rnd_cmd(int span);
        los_cmd_t c;
        int p, r0, c0;
        p = int'($urandom_range(99));
        r0 = int'(rnd_crd(rows_used)); c0 = int'(rnd_crd(cols_used));
        if (p < 2) c.cmd = glos_pkg::CMD_CLEAR;
        else if (p < 4) c.cmd = glos_pkg::CMD_NOP;
        else if (p < 30) c.cmd = glos_pkg::CMD_RECT;
        else c.cmd = glos_pkg::CMD_QUERY;
        c.ra = 8'(r0); c.ca = 8'(c0);
        if (c.cmd == glos_pkg::CMD_RECT) begin
            // small blocks, sometimes inverted
            c.rb = ($urandom_range(9) == 0) ? rnd_crd(rows_used)
                                            : 8'((r0 + int'($urandom_range(3))) % 256);
            c.cb = ($urandom_range(9) == 0) ? rnd_crd(cols_used)
                                            : 8'((c0 + int'($urandom_range(3))) % 256);
        end else if ($urandom_range(3) == 0) begin
            c.rb = rnd_crd(rows_used); c.cb = rnd_crd(cols_used);
        end else begin
            c.rb = 8'((r0 + int'($urandom_range(2*span)) - span + 256) % 256);
            c.cb = 8'((c0 + int'($urandom_range(2*span)) - span + 256) % 256);
            if ($urandom_range(7) == 0) c.rb = c.ra;
            else if ($urandom_range(7) == 0) c.cb = c.ca;
        end
        return c;
    endfunction

    // result checker
    always @(posedge aclk) begin
        los_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.vis = m_tdata[0];
            got.bad = m_tdata[1];
            if (exp_q.size() == 0) begin
                $error("result beat with nothing expected: %b", m_tdata);
                n_fail++;
            end else begin
                want = exp_q.pop_front();
                if (got.vis !== want.vis) begin
                    $error("visible: expected %b actual %b", want.vis, got.vis);
                    n_fail++;
                end
                if (got.bad !== want.bad) begin
                    $error("bad_coords: expected %b actual %b", want.bad, got.bad);
                    n_fail++;
                end
                if (m_tdata[glos_pkg::OUT_W-1:2] !== '0) begin
                    $error("pad: expected 0 actual %h", m_tdata[glos_pkg::OUT_W-1:2]);
                    n_fail++;
                end
            end
        end
    end

    // receiver stalls; a long hold-off counted here while the sender keeps offering
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_rx = 0;
            end
            g = gap_len();
            if (g == 0 || $urandom_range(3) == 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    dir_row_t dir_tab[$];

    initial begin
        los_res_t z;
        n_fail = 0;
        rows_used = 256; cols_used = 256;
        z = '0;
        tick(10);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset: 256x256, everything free
        dir_tab = '{
            '{mk(glos_pkg::CMD_QUERY, 0, 0, 255, 255), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 255, 0, 0, 255), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 7, 7, 7, 7), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_NOP, 255, 255, 255, 255), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_RECT, 10, 10, 10, 10), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 10, 0, 10, 10), 1, '{1'b1, 1'b0}},  // straight, end untested
            '{mk(glos_pkg::CMD_QUERY, 10, 0, 10, 20), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 0, 10, 10, 10), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 0, 0, 10, 10), 1, '{1'b0, 1'b0}},   // diagonal tests end
            '{mk(glos_pkg::CMD_QUERY, 3, 1, 17, 6), 0, z},
            '{mk(glos_pkg::CMD_QUERY, 20, 2, 1, 14), 0, z},
            '{mk(glos_pkg::CMD_RECT, 50, 60, 40, 70), 1, '{1'b0, 1'b0}},  // inverted: no mark
            '{mk(glos_pkg::CMD_QUERY, 45, 60, 45, 80), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_RECT, 250, 250, 255, 255), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 200, 240, 255, 255), 0, z},
            '{mk(glos_pkg::CMD_CLEAR, 0, 0, 0, 0), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 0, 0, 10, 10), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_RECT, 0, 0, 255, 255), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 5, 5, 5, 5), 1, '{1'b1, 1'b0}},
            '{mk(glos_pkg::CMD_QUERY, 0, 0, 0, 1), 1, '{1'b0, 1'b0}},
            '{mk(glos_pkg::CMD_CLEAR, 255, 255, 255, 255), 1, '{1'b0, 1'b0}}
        };
        foreach (dir_tab[k]) send_cmd(dir_tab[k].c, dir_tab[k].has_exp, dir_tab[k].e);
        drain();

        // small grid: endpoints off it are flagged, marks beyond it clipped
        write_reg(glos_pkg::REG_GRID_ROWS, 9'd20);
        write_reg(glos_pkg::REG_GRID_COLS, 9'd30);
        send_cmd(mk(glos_pkg::CMD_QUERY, 20, 0, 0, 0), 1, '{1'b0, 1'b1});
        send_cmd(mk(glos_pkg::CMD_QUERY, 0, 0, 0, 30), 1, '{1'b0, 1'b1});
        send_cmd(mk(glos_pkg::CMD_RECT, 15, 25, 40, 40), 1, '{1'b0, 1'b0});
        send_cmd(mk(glos_pkg::CMD_QUERY, 19, 0, 19, 29), 1, '{1'b0, 1'b0});
        drain();

        // random phases over several grid settings, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            logic [glos_pkg::DIM_W-1:0] rv, cv;
            int span;
            case (ph)
                0: begin rv = 9'd256; cv = 9'd256; end
                1: begin rv = 9'd0;   cv = 9'd511; end
                2: begin rv = 9'd1;   cv = 9'd2;   end
                3: begin rv = 9'd300; cv = 9'd0;   end
                4: begin rv = 9'd12;  cv = 9'd40;  end
                default: begin
                    rv = 9'($urandom_range(1, 511));
                    cv = 9'($urandom_range(1, 511));
                end
            endcase
            write_reg(glos_pkg::REG_GRID_ROWS, rv);
            write_reg(glos_pkg::REG_GRID_COLS, cv);
            span = (ph == 0) ? 60 : 12;
            if (ph == 2) hold_rx = 1;   // block fills up and stalls its input
            for (int n = 0; n < 95; n++) begin
                send_cmd(rnd_cmd(($urandom_range(19) == 0) ? 255 : span), 0, z);
                if (n == 50) drain();    // sender pauses until all results are in
            end
            drain();
        end

        if (n_fail == 0 && exp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #30000000;
        $display("simulation failed");
        $finish;
    end
endmodule
